[sv/avlg_pkg.sv]
`default_nettype none

package avlg_pkg;

    localparam int LINE_CYCLES = 64;
    localparam int SYNC_END    = 5;
    localparam int PIXEL_START = 16;
    localparam int PIXEL_END   = 56;
    localparam int PIXEL_LINES = 200;
    localparam int FRAME_LINES = 312;

    localparam int ZONE_END = (PIXEL_LINES - 1) * LINE_CYCLES + PIXEL_END;

    localparam int COL_W   = $clog2(LINE_CYCLES);
    localparam int LINE_W  = $clog2(FRAME_LINES);
    localparam int FRAME_W = 15;
    localparam int ADDR_W  = 13;
    localparam int RGB_W   = 12;
    localparam int NPIX    = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 120;

    localparam logic [7:0] STATUS_ONE    = 8'h01;
    localparam logic [7:0] STATUS_WINDOW = 8'h20;
    localparam logic [7:0] STATUS_ZONE   = 8'h80;

    typedef enum logic [1:0] {
        REG_SYNC   = 2'd0,
        REG_BORDER = 2'd1,
        REG_PIXELS = 2'd2
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BORDER     = 3'd0,
        CFG_VSYNC_LINE = 3'd1,
        CFG_VSYNC_CNT  = 3'd2,
        CFG_IRQ_START  = 3'd3,
        CFG_IRQ_LEN    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  border_colour;
        logic [8:0]  vsync_first_line;
        logic [8:0]  vsync_line_count;
        logic [14:0] irq_start_cycle;
        logic [7:0]  irq_pulse_length;
    } t_cfg;

    typedef struct packed {
        t_region           region;
        logic [7:0]        pixel_byte;
        logic [7:0]        attr_byte;
        logic [3:0]        border;
        logic              irq_level;
        logic [7:0]        status_byte;
        logic [ADDR_W-1:0] fetch_address;
    } t_s1;

    function automatic logic [RGB_W-1:0] palette(input logic [3:0] idx);
        logic [RGB_W-1:0] c;
        case (idx)
            4'd0:    c = 12'h000;
            4'd1:    c = 12'hf55;
            4'd2:    c = 12'h0f0;
            4'd3:    c = 12'hff0;
            4'd4:    c = 12'h55f;
            4'd5:    c = 12'hf0f;
            4'd6:    c = 12'h5ff;
            4'd7:    c = 12'hfff;
            4'd8:    c = 12'haaa;
            4'd9:    c = 12'hfaa;
            4'd10:   c = 12'hafa;
            4'd11:   c = 12'hffa;
            4'd12:   c = 12'h5af;
            4'd13:   c = 12'hfaf;
            4'd14:   c = 12'haff;
            4'd15:   c = 12'hfa5;
            default: c = 12'h000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/avlg_timing.sv]
`default_nettype none

module avlg_timing
    import avlg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,
    output logic                       o_s_tready,
    input  wire t_cfg                  i_cfg,
    output logic                       o_s1_valid,
    output t_s1                        o_s1,
    input  wire logic                  i_s2_ready
);

    logic [COL_W-1:0]   r_col, n_col;
    logic [LINE_W-1:0]  r_line, n_line;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [ADDR_W-1:0]  r_src, n_src;
    logic               r_valid;
    t_s1                r_s1, n_s1;
    logic               accept;
    logic               in_vsync, zone, window, irq;
    t_region            region;
    logic [9:0]         vs_end;
    logic [15:0]        irq_end;

    assign o_s_tready = !r_valid || i_s2_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        vs_end   = 10'(i_cfg.vsync_first_line) + 10'(i_cfg.vsync_line_count);
        in_vsync = (10'(r_line) >= 10'(i_cfg.vsync_first_line)) && (10'(r_line) < vs_end);
        if (in_vsync) begin
            region = REG_SYNC;
        end else if (32'(r_col) < 32'(SYNC_END)) begin
            region = REG_SYNC;
        end else if (32'(r_line) >= 32'(PIXEL_LINES)) begin
            region = REG_BORDER;
        end else if (32'(r_col) < 32'(PIXEL_START)) begin
            region = REG_BORDER;
        end else if (32'(r_col) < 32'(PIXEL_END)) begin
            region = REG_PIXELS;
        end else begin
            region = REG_BORDER;
        end

        irq_end = 16'(i_cfg.irq_start_cycle) + 16'(i_cfg.irq_pulse_length);
        irq     = (r_frame >= i_cfg.irq_start_cycle) && (16'(r_frame) < irq_end);

        zone   = (32'(r_frame) >= 32'(PIXEL_START)) && (32'(r_frame) < 32'(ZONE_END));
        window = zone && (32'(r_col) >= 32'(PIXEL_START)) && (32'(r_col) < 32'(PIXEL_END));
    end

    always_comb begin
        n_col   = r_col;
        n_line  = r_line;
        n_frame = r_frame;
        n_src   = r_src;
        if (accept) begin
            if (region == REG_PIXELS) begin
                n_src = r_src + 1'b1;
            end
            n_frame = r_frame + 1'b1;
            if (32'(r_col) == LINE_CYCLES - 1) begin
                n_col = '0;
                if (32'(r_line) == FRAME_LINES - 1) begin
                    n_line  = '0;
                    n_frame = '0;
                    n_src   = '0;
                end else begin
                    n_line = r_line + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_comb begin
        n_s1.region        = region;
        n_s1.pixel_byte    = i_s_tdata[7:0];
        n_s1.attr_byte     = i_s_tdata[15:8];
        n_s1.border        = i_cfg.border_colour;
        n_s1.irq_level     = irq;
        n_s1.status_byte   = STATUS_ONE | (window ? 8'h00 : STATUS_WINDOW)
                           | (zone ? 8'h00 : STATUS_ZONE);
        n_s1.fetch_address = n_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_line  <= '0;
            r_frame <= '0;
            r_src   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_line  <= n_line;
            r_frame <= n_frame;
            r_src   <= n_src;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_s2_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1       = r_s1;

endmodule

`default_nettype wire

[sv/avlg_colour.sv]
`default_nettype none

module avlg_colour
    import avlg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s1_valid,
    input  wire t_s1                    i_s1,
    output logic                        o_s2_ready,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]                  o_m_tuser,
    input  wire logic                   i_m_tready
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_tdata, n_tdata;
    logic [1:0]             r_tuser;
    logic [RGB_W-1:0]       fg, bg, bd;
    logic                   load;

    assign o_s2_ready = !r_valid || i_m_tready;
    assign load       = i_s1_valid && o_s2_ready;

    always_comb begin
        fg      = palette(i_s1.attr_byte[7:4]);
        bg      = palette(i_s1.attr_byte[3:0]);
        bd      = palette(i_s1.border);
        n_tdata = '0;
        for (int k = 0; k < NPIX; k++) begin
            case (i_s1.region)
                REG_PIXELS: n_tdata[k*RGB_W +: RGB_W] = i_s1.pixel_byte[NPIX-1-k] ? fg : bg;
                REG_BORDER: n_tdata[k*RGB_W +: RGB_W] = bd;
                default:    n_tdata[k*RGB_W +: RGB_W] = '0;
            endcase
        end
        n_tdata[NPIX*RGB_W]                 = i_s1.irq_level;
        n_tdata[NPIX*RGB_W+1 +: 8]          = i_s1.status_byte;
        n_tdata[NPIX*RGB_W+9 +: ADDR_W]     = i_s1.fetch_address;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= n_tdata;
            r_tuser <= i_s1.region;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

endmodule

`default_nettype wire

[sv/attribute_video_line_generator.sv]
// Attribute video line generator.
// One input word per video cycle on s_axis: the bitmap and attribute bytes
// read at the fetch address carried by the previous output word.
// One output word per input word on m_axis: tuser gives the cycle kind
// (sync, border, pixels); tdata carries eight 12-bit colours, the frame
// interrupt level, the vertical status byte and the next fetch address.
// Line, column and frame-cycle counters advance on each accepted word.
// The timing stage registers the cycle class, then the colour stage expands
// the byte through the palette into the output register. Throughput is one
// word per clock while m_axis_tready stays high; the two register stages each
// have their own valid, so a new word is taken while a result waits.
// When m_axis_tready is low the output holds, the timing stage fills, and
// s_axis_tready drops only once both stages are full.
// Reset (synchronous, active low) clears the counters, empties both stages
// and loads the register defaults: border 0, vsync from line 256 for 3 lines,
// interrupt from frame cycle 0, pulse length 8. The user writes registers
// through i_cfg_we/i_cfg_index/i_cfg_wdata while idle; the block does not enforce it.
`default_nettype none

module attribute_video_line_generator
    import avlg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] pixel_byte, [15:8] attr_byte
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [95:0] colour_0..colour_7 (12 bits each), [96] irq_level,
    // [104:97] status_byte, [117:105] fetch_address, [119:118] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] region
    output logic [1:0]                  m_axis_tuser,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg r_cfg;
    logic s1_valid;
    t_s1  s1;
    logic s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.border_colour    <= 4'd0;
            r_cfg.vsync_first_line <= 9'd256;
            r_cfg.vsync_line_count <= 9'd3;
            r_cfg.irq_start_cycle  <= 15'd0;
            r_cfg.irq_pulse_length <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BORDER:     r_cfg.border_colour    <= i_cfg_wdata[3:0];
                CFG_VSYNC_LINE: r_cfg.vsync_first_line <= i_cfg_wdata[8:0];
                CFG_VSYNC_CNT:  r_cfg.vsync_line_count <= i_cfg_wdata[8:0];
                CFG_IRQ_START:  r_cfg.irq_start_cycle  <= i_cfg_wdata[14:0];
                CFG_IRQ_LEN:    r_cfg.irq_pulse_length <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    avlg_timing u_timing (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tdata  (s_axis_tdata),
        .o_s_tready (s_axis_tready),
        .i_cfg      (r_cfg),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s2_ready (s2_ready)
    );

    avlg_colour u_colour (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s2_ready (s2_ready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .i_m_tready (m_axis_tready)
    );

`ifndef SYNTH
    a_sync_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == REG_SYNC) |-> (m_axis_tdata[95:0] == '0))
        else $error("sync word with non-black colour");

    a_status_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[97])
        else $error("status bit 0 clear");

    a_window_in_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[102] |-> !m_axis_tdata[104])
        else $error("pixel window outside pixel zone");

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken with both stages full");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
    import avlg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 400;

    localparam logic [RGB_W-1:0] RGB_LUT [16] = '{
        12'h000, 12'hf55, 12'h0f0, 12'hff0, 12'h55f, 12'hf0f, 12'h5ff, 12'hfff,
        12'haaa, 12'hfaa, 12'hafa, 12'hffa, 12'h5af, 12'hfaf, 12'haff, 12'hfa5
    };

    typedef struct packed {
        t_region                    region;
        logic [NPIX-1:0][RGB_W-1:0] colour;
        logic                       irq;
        logic [7:0]                 status;
        logic [ADDR_W-1:0]          addr;
    } t_vid_word;

    typedef struct {
        logic [7:0]        pix;
        logic [7:0]        attr;
        bit                typed;
        t_region           region;
        logic [RGB_W-1:0]  fg;
        logic [RGB_W-1:0]  bg;
        logic              irq;
        logic [7:0]        status;
        logic [ADDR_W-1:0] addr;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire logic              s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    wire logic              m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire logic [OUT_TDATA_W-1:0] m_axis_tdata;
    wire logic [1:0]        m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    attribute_video_line_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // register shadows, reset values
    int cfg_border    = 0;
    int cfg_vs_first  = 256;
    int cfg_vs_count  = 3;
    int cfg_irq_start = 0;
    int cfg_irq_len   = 8;

    // beam position
    int beam_col   = 0;
    int beam_line  = 0;
    int beam_frame = 0;
    int fetch_ptr  = 0;

    t_vid_word pending_words [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    int mismatches    = 0;
    int words_checked = 0;
    int words_sent    = 0;
    int frame_wraps   = 0;
    int region_hits [3] = '{0, 0, 0};

    t_stim_row dir_rows [25];

    function automatic t_vid_word advance_beam(input logic [7:0] pix, input logic [7:0] attr);
        t_vid_word w;
        bit        vsync;
        bit        zone;
        bit        window;
        vsync = beam_line >= cfg_vs_first && beam_line < cfg_vs_first + cfg_vs_count;
        if (vsync || beam_col < SYNC_END) begin
            w.region = REG_SYNC;
        end else if (beam_line >= PIXEL_LINES || beam_col < PIXEL_START ||
                     beam_col >= PIXEL_END) begin
            w.region = REG_BORDER;
        end else begin
            w.region = REG_PIXELS;
        end
        for (int k = 0; k < NPIX; k++) begin
            case (w.region)
                REG_PIXELS: w.colour[k] = pix[7-k] ? RGB_LUT[attr[7:4]] : RGB_LUT[attr[3:0]];
                REG_BORDER: w.colour[k] = RGB_LUT[cfg_border];
                default:    w.colour[k] = '0;
            endcase
        end
        w.irq = beam_frame >= cfg_irq_start && beam_frame < cfg_irq_start + cfg_irq_len;
        zone   = beam_frame >= PIXEL_START && beam_frame < ZONE_END;
        window = zone && beam_col >= PIXEL_START && beam_col < PIXEL_END;
        w.status = STATUS_ONE | (window ? 8'h00 : STATUS_WINDOW) | (zone ? 8'h00 : STATUS_ZONE);
        region_hits[w.region]++;

        if (w.region == REG_PIXELS)
            fetch_ptr = (fetch_ptr + 1) % (1 << ADDR_W);
        beam_col++;
        beam_frame = (beam_frame + 1) % (1 << FRAME_W);
        if (beam_col >= LINE_CYCLES) begin
            beam_col = 0;
            beam_line++;
            if (beam_line >= FRAME_LINES) begin
                beam_line  = 0;
                beam_frame = 0;
                fetch_ptr  = 0;
                frame_wraps++;
            end
        end
        w.addr = fetch_ptr[ADDR_W-1:0];
        return w;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        t_vid_word want;
        t_vid_word got;
        got.region = t_region'(m_axis_tuser);
        got.colour = m_axis_tdata[NPIX*RGB_W-1:0];
        got.irq    = m_axis_tdata[96];
        got.status = m_axis_tdata[104:97];
        got.addr   = m_axis_tdata[117:105];
        if (pending_words.size() == 0) begin
            $error("output word with nothing expected");
            mismatches++;
        end else begin
            want = pending_words.pop_front();
            words_checked++;
            check_field("region", 16'(want.region), 16'(got.region));
            for (int k = 0; k < NPIX; k++)
                check_field($sformatf("colour_%0d", k), 16'(want.colour[k]),
                            16'(got.colour[k]));
            check_field("irq_level", 16'(want.irq), 16'(got.irq));
            check_field("status_byte", 16'(want.status), 16'(got.status));
            check_field("fetch_address", 16'(want.addr), 16'(got.addr));
        end
    endtask

    // output side: check, then pick next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_word();
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(input logic [7:0] pix, input logic [7:0] attr);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {attr, pix};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_words.push_back(advance_beam(pix, attr));
        words_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [14:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_BORDER:     cfg_border    = val[3:0];
            CFG_VSYNC_LINE: cfg_vs_first  = val[8:0];
            CFG_VSYNC_CNT:  cfg_vs_count  = val[8:0];
            CFG_IRQ_START:  cfg_irq_start = val[14:0];
            CFG_IRQ_LEN:    cfg_irq_len   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [14:0] border, input logic [14:0] vs_first,
                            input logic [14:0] vs_count, input logic [14:0] irq_start,
                            input logic [14:0] irq_len);
        write_reg(CFG_BORDER, border);
        write_reg(CFG_VSYNC_LINE, vs_first);
        write_reg(CFG_VSYNC_CNT, vs_count);
        write_reg(CFG_IRQ_START, irq_start);
        write_reg(CFG_IRQ_LEN, irq_len);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n, input int s_pct, input int r_pct, input bit squeeze);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if (squeeze && i == 100)
                hold_req = 1'b1;
            if (squeeze && i == 300)
                drain();
            send_word(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        drain();
    endtask

    initial begin : stimulus
        t_vid_word typed_word;
        dir_rows = '{
            '{8'h00, 8'h00, 1'b1, REG_SYNC,   12'h000, 12'h000, 1'b1, 8'ha1, 13'd0},
            '{8'hff, 8'hff, 1'b1, REG_SYNC,   12'h000, 12'h000, 1'b1, 8'ha1, 13'd0},
            '{8'h7e, 8'h81, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h81, 8'h7e, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h5a, 8'ha5, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'hff, 8'hff, 1'b1, REG_BORDER, 12'h000, 12'h000, 1'b1, 8'ha1, 13'd0},
            '{8'h12, 8'h34, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'hed, 8'hcb, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h00, 8'hff, 1'b1, REG_BORDER, 12'h000, 12'h000, 1'b0, 8'ha1, 13'd0},
            '{8'h69, 8'h96, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'hf0, 8'h0f, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h0f, 8'hf0, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h33, 8'hcc, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'hcc, 8'h33, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h01, 8'h80, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'h80, 8'h01, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'hff, 8'hf0, 1'b1, REG_PIXELS, 12'hfa5, 12'h000, 1'b0, 8'h01, 13'd1},
            '{8'h00, 8'hf0, 1'b1, REG_PIXELS, 12'hfa5, 12'h000, 1'b0, 8'h01, 13'd2},
            '{8'haa, 8'h71, 1'b1, REG_PIXELS, 12'hfff, 12'hf55, 1'b0, 8'h01, 13'd3},
            '{8'h55, 8'h71, 1'b1, REG_PIXELS, 12'hfff, 12'hf55, 1'b0, 8'h01, 13'd4},
            '{8'h0f, 8'h0f, 1'b1, REG_PIXELS, 12'h000, 12'hfa5, 1'b0, 8'h01, 13'd5},
            '{8'h80, 8'he8, 1'b1, REG_PIXELS, 12'haff, 12'haaa, 1'b0, 8'h01, 13'd6},
            '{8'h01, 8'hc9, 1'b1, REG_PIXELS, 12'h5af, 12'hfaa, 1'b0, 8'h01, 13'd7},
            '{8'h3c, 8'h2d, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0},
            '{8'hc3, 8'hb4, 1'b0, REG_SYNC,   12'h000, 12'h000, 1'b0, 8'h00, 13'd0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // line 0 from column 0 at reset settings
        send_idle_pct = 37;
        recv_idle_pct = 48;
        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].pix, dir_rows[r].attr);
            if (dir_rows[r].typed) begin
                typed_word.region = dir_rows[r].region;
                for (int k = 0; k < NPIX; k++)
                    typed_word.colour[k] = dir_rows[r].pix[7-k] ? dir_rows[r].fg
                                                                : dir_rows[r].bg;
                typed_word.irq    = dir_rows[r].irq;
                typed_word.status = dir_rows[r].status;
                typed_word.addr   = dir_rows[r].addr;
                pending_words[pending_words.size()-1] = typed_word;
            end
        end
        drain();

        // vsync over two pixel lines; upper bits of border write dropped
        set_mode(15'h7ff3, 15'd3, 15'd2, 15'd100, 15'd255);
        run_random(400, 37, 48, 1'b0);

        // everything sync, irq never fires
        set_mode(15'd0, 15'd0, 15'd511, 15'd32767, 15'd0);
        run_random(400, 48, 37, 1'b0);

        // no vsync, irq pulse just ahead, long output stall
        set_mode(15'($urandom_range(1, 14)), 15'd511, 15'd0, 15'(beam_frame + 150),
                 15'($urandom_range(1, 254)));
        run_random(400, 0, 0, 1'b1);

        // single vsync line next, irq pulse starting shortly
        set_mode(15'd15, 15'(beam_line + 1), 15'd1, 15'(beam_frame + 20), 15'd200);
        run_random(125, 0, 0, 1'b0);

        $display("Video cycles driven: %0d (%0d sync, %0d border, %0d pixel), %0d frame wrap(s).",
                 words_sent, region_hits[REG_SYNC], region_hits[REG_BORDER],
                 region_hits[REG_PIXELS], frame_wraps);
        $display("Words checked: %0d over five register settings, %0d mismatch(es).",
                 words_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/avlg_pkg.sv
sv/avlg_timing.sv
sv/avlg_colour.sv
sv/attribute_video_line_generator.sv
tb/sv/tb.sv
